[hdl/bbs_pkg.sv]
// bbs_pkg: word types, bin geometry and fixed-point constants for the
// binned backscatter statistics block; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bbs_pkg;

  // bin table geometry
  localparam int SPEED_BINS   = 20;
  localparam int AZIMUTH_BINS = 72;
  localparam int RAIN_BINS    = 61;
  localparam int BEAM_COUNT   = 2;
  localparam int TOTAL_BINS   = BEAM_COUNT * SPEED_BINS * AZIMUTH_BINS * RAIN_BINS;

  localparam int ADDR_W     = (TOTAL_BINS > 1) ? $clog2(TOTAL_BINS) : 1;
  localparam int T1_W       = (BEAM_COUNT * SPEED_BINS > 1) ?
                              $clog2(BEAM_COUNT * SPEED_BINS) : 1;
  localparam int T2_W       = (BEAM_COUNT * SPEED_BINS * AZIMUTH_BINS > 1) ?
                              $clog2(BEAM_COUNT * SPEED_BINS * AZIMUTH_BINS) : 1;
  localparam int CHI_BIN_W  = (AZIMUTH_BINS > 1) ? $clog2(AZIMUTH_BINS) : 1;
  localparam int RAIN_BIN_W = (RAIN_BINS > 1) ? $clog2(RAIN_BINS) : 1;
  localparam int BEAM_W     = (BEAM_COUNT > 1) ? $clog2(BEAM_COUNT) : 1;

  // angles in hundredths of a degree
  localparam int CHI_FULL   = 36000;
  localparam int CHI_OFFSET = 90000;   // half turn plus two full turns
  localparam int WRAP_W     = 18;

  // chi bin = chi * AZIMUTH_BINS / CHI_FULL through a reciprocal
  localparam int     P_W       = $clog2(CHI_FULL * AZIMUTH_BINS);
  localparam int     CHI_SHIFT = 40;
  localparam longint CHI_RECIP = (64'd1 << CHI_SHIFT) / CHI_FULL;
  localparam int     RECIP_W   = $clog2(CHI_RECIP + 1);

  // rain bin steps of five raw units; exact for 16-bit values
  localparam int RAIN_STEP  = 5;
  localparam int RAIN_SHIFT = 18;
  localparam int RAIN_RECIP = ((1 << RAIN_SHIFT) + RAIN_STEP - 1) / RAIN_STEP;
  localparam int IRAIN_W    = 14;

  localparam int COLOC_CENTER = 180;

  // cycles from launch to a finished bin index
  localparam int IDX_LAT = 7;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLOC = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RAIN  = 1'd1;
  localparam logic [7:0]  COLOC_RESET = 8'd30;
  localparam logic [15:0] RAIN_RESET  = 16'd1000;

  // result status codes
  localparam logic [1:0] STAT_ACC   = 2'd0;
  localparam logic [1:0] STAT_SPEED = 2'd1;
  localparam logic [1:0] STAT_RAIN  = 2'd2;
  localparam logic [1:0] STAT_READ  = 2'd3;

  localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;
  localparam logic [47:0] SUM48_MAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic [62:0] SQUARE_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic              mode;
    logic              beam;
    logic [15:0]       wind_speed;
    logic [15:0]       wind_dir;
    logic [15:0]       meas_azimuth;
    logic signed [31:0] sigma0;
    logic [7:0]        time_offset;
    logic [15:0]       rain_raw;
    logic [17:0]       read_bin;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [17:0]        bin_address;
    logic [31:0]        bin_count;
    logic signed [63:0] bin_sum_sigma0;
    logic [62:0]        bin_sum_square;
    logic [47:0]        bin_sum_speed;
    logic [47:0]        bin_sum_chi;
    logic [47:0]        bin_sum_rain;
  } result_t;

  // one row of the bin store
  typedef struct packed {
    logic [31:0]        count;
    logic signed [63:0] sum_sigma0;
    logic [62:0]        sum_square;
    logic [47:0]        sum_speed;
    logic [47:0]        sum_chi;
    logic [47:0]        sum_rain;
  } entry_t;

  // finished bin index and drop decision
  typedef struct packed {
    logic              valid;
    logic              fetch;
    logic [1:0]        status;
    logic [ADDR_W-1:0] addr;
    logic [17:0]       bin_address;
    logic [15:0]       chi;
    logic [62:0]       square;
  } idx_t;

endpackage
`default_nettype wire

[hdl/bbs_index.sv]
// bbs_index: seven-stage pipeline that turns one held word into a flat bin
// address, a drop status, chi and sigma0 squared; uses bbs_pkg
`timescale 1ns / 1ps
`default_nettype none
module bbs_index import bbs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        launch,
  input  wire item_t       item,
  input  wire logic [7:0]  colocation_limit,
  input  wire logic [15:0] rain_limit,
  output idx_t             idx
);

  localparam int PROD_W = P_W + RECIP_W;

  logic [IDX_LAT-1:0] vld;

  // stage 1
  logic [7:0]        ispd_r;
  logic              speed_bad_r;
  logic              rain_over_r;
  logic [WRAP_W-1:0] wrap_r;
  logic [31:0]       rain_prod_r;
  logic [62:0]       square_r;
  // stage 2
  logic [15:0]       chi_r;
  logic [IRAIN_W-1:0] irain_r;
  logic [T1_W-1:0]   t1_r;
  // stage 3..6
  logic [P_W-1:0]       p_r;
  logic                 rain_bad_r;
  logic [CHI_BIN_W-1:0] qest_r;
  logic [CHI_BIN_W-1:0] ichi_r;
  logic [T2_W-1:0]      t2_r;
  // stage 7
  logic              fetch_r;
  logic [1:0]        status_r;
  logic [ADDR_W-1:0] addr_r;
  logic [17:0]       bin_address_r;

  logic [8:0]         toff2;
  logic [8:0]         co;
  logic signed [63:0] sq_full;
  logic [2:0]         turns;
  logic [WRAP_W-1:0]  wrap_sub;
  logic [BEAM_W-1:0]  beam_c;
  logic [PROD_W-1:0]  qprod;
  logic [P_W:0]       rem;
  logic [ADDR_W-1:0]  addr_calc;
  logic               read_in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[IDX_LAT-2:0], launch};
    end
  end

  // stage 1: range checks, chi before wrap, reciprocal and square products
  assign toff2   = {item.time_offset, 1'b0};
  assign co      = (toff2 >= 9'(COLOC_CENTER)) ? toff2 - 9'(COLOC_CENTER)
                                               : 9'(COLOC_CENTER) - toff2;
  assign sq_full = item.sigma0 * item.sigma0;

  always_ff @(posedge clk) begin
    ispd_r      <= item.wind_speed[15:8];
    speed_bad_r <= (32'(item.wind_speed[15:8]) >= 32'(SPEED_BINS));
    rain_over_r <= (co > {1'b0, colocation_limit}) || (item.rain_raw > rain_limit);
    wrap_r      <= WRAP_W'(item.wind_dir) + WRAP_W'(CHI_OFFSET) - WRAP_W'(item.meas_azimuth);
    rain_prod_r <= 32'(item.rain_raw) * 32'(RAIN_RECIP);
    square_r    <= sq_full[62:0];
  end

  // stage 2: wrap chi into one turn, rain bin, beam and speed part
  always_comb begin
    if (wrap_r >= WRAP_W'(4 * CHI_FULL)) begin
      turns = 3'd4;
    end else if (wrap_r >= WRAP_W'(3 * CHI_FULL)) begin
      turns = 3'd3;
    end else if (wrap_r >= WRAP_W'(2 * CHI_FULL)) begin
      turns = 3'd2;
    end else if (wrap_r >= WRAP_W'(CHI_FULL)) begin
      turns = 3'd1;
    end else begin
      turns = 3'd0;
    end
    wrap_sub = WRAP_W'(turns) * WRAP_W'(CHI_FULL);
    beam_c   = (32'(item.beam) >= 32'(BEAM_COUNT)) ? BEAM_W'(BEAM_COUNT - 1)
                                                   : BEAM_W'(item.beam);
  end

  always_ff @(posedge clk) begin
    chi_r   <= 16'(wrap_r - wrap_sub);
    irain_r <= (item.rain_raw == 16'd0) ? '0
             : IRAIN_W'(rain_prod_r >> RAIN_SHIFT) + IRAIN_W'(1);
    t1_r    <= T1_W'(32'(beam_c) * 32'(SPEED_BINS) + 32'(ispd_r));
  end

  // stages 3 to 5: chi bin by reciprocal with one correction step
  assign qprod = PROD_W'(p_r) * PROD_W'(CHI_RECIP);
  assign rem   = {1'b0, p_r} - ((P_W + 1)'(qest_r) * (P_W + 1)'(CHI_FULL));

  always_ff @(posedge clk) begin
    p_r        <= P_W'(chi_r) * P_W'(AZIMUTH_BINS);
    rain_bad_r <= rain_over_r || (32'(irain_r) >= 32'(RAIN_BINS));
    qest_r     <= CHI_BIN_W'(qprod >> CHI_SHIFT);
    ichi_r     <= (rem >= (P_W + 1)'(CHI_FULL)) ? qest_r + CHI_BIN_W'(1) : qest_r;
    t2_r       <= T2_W'(32'(t1_r) * 32'(AZIMUTH_BINS) + 32'(ichi_r));
  end

  // stage 7: flat address and the decision
  assign addr_calc     = ADDR_W'(32'(t2_r) * 32'(RAIN_BINS)
                                 + 32'(irain_r[RAIN_BIN_W-1:0]));
  assign read_in_range = (32'(item.read_bin) < 32'(TOTAL_BINS));

  always_ff @(posedge clk) begin
    if (item.mode) begin
      status_r      <= STAT_READ;
      fetch_r       <= read_in_range;
      addr_r        <= ADDR_W'(item.read_bin);
      bin_address_r <= item.read_bin;
    end else if (speed_bad_r) begin
      status_r      <= STAT_SPEED;
      fetch_r       <= 1'b0;
      addr_r        <= '0;
      bin_address_r <= '0;
    end else if (rain_bad_r) begin
      status_r      <= STAT_RAIN;
      fetch_r       <= 1'b0;
      addr_r        <= '0;
      bin_address_r <= '0;
    end else begin
      status_r      <= STAT_ACC;
      fetch_r       <= 1'b1;
      addr_r        <= addr_calc;
      bin_address_r <= 18'(addr_calc);
    end
  end

  assign idx.valid       = vld[IDX_LAT-1];
  assign idx.fetch       = fetch_r;
  assign idx.status      = status_r;
  assign idx.addr        = addr_r;
  assign idx.bin_address = bin_address_r;
  assign idx.chi         = chi_r;
  assign idx.square      = square_r;

endmodule
`default_nettype wire

[hdl/bbs_update.sv]
// bbs_update: saturating update of one bin row with one measurement
// uses bbs_pkg
`timescale 1ns / 1ps
`default_nettype none
module bbs_update import bbs_pkg::*; (
  input  wire entry_t             old_row,
  input  wire logic signed [31:0] sigma0,
  input  wire logic [62:0]        square,
  input  wire logic [15:0]        speed,
  input  wire logic [15:0]        chi,
  input  wire logic [15:0]        rain,
  output entry_t                  new_row
);

  logic signed [64:0] sig_sum;
  logic [63:0]        sq_sum;
  logic [48:0]        spd_sum;
  logic [48:0]        chi_sum;
  logic [48:0]        rain_sum;

  assign sig_sum  = 65'(old_row.sum_sigma0) + 65'(sigma0);
  assign sq_sum   = {1'b0, old_row.sum_square} + {1'b0, square};
  assign spd_sum  = {1'b0, old_row.sum_speed} + 49'(speed);
  assign chi_sum  = {1'b0, old_row.sum_chi} + 49'(chi);
  assign rain_sum = {1'b0, old_row.sum_rain} + 49'(rain);

  always_comb begin
    new_row.count = (old_row.count == COUNT_MAX) ? COUNT_MAX : old_row.count + 32'd1;
    // signed overflow shows as a mismatch of the two top bits
    if (sig_sum[64] != sig_sum[63]) begin
      new_row.sum_sigma0 = sig_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      new_row.sum_sigma0 = sig_sum[63:0];
    end
    new_row.sum_square = sq_sum[63] ? SQUARE_MAX : sq_sum[62:0];
    new_row.sum_speed  = spd_sum[48] ? SUM48_MAX : spd_sum[47:0];
    new_row.sum_chi    = chi_sum[48] ? SUM48_MAX : chi_sum[47:0];
    new_row.sum_rain   = rain_sum[48] ? SUM48_MAX : rain_sum[47:0];
  end

endmodule
`default_nettype wire

[hdl/bbs_store.sv]
// bbs_store: bin table memory, one write and one registered read a cycle,
// with a clearing sweep after reset; uses bbs_pkg
`timescale 1ns / 1ps
`default_nettype none
module bbs_store import bbs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output entry_t                 rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire entry_t            wr_data,
  output logic                   ready
);

  entry_t            mem [TOTAL_BINS];
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  entry_t            mem_din;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_W'(TOTAL_BINS - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  assign mem_we   = clearing || wr_en;
  assign mem_addr = clearing ? clr_addr : wr_addr;
  assign mem_din  = clearing ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_din;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign ready = !clearing;

endmodule
`default_nettype wire

[hdl/binned_backscatter_statistics.sv]
// binned_backscatter_statistics: top level with config registers, sequencer
// and result register; uses bbs_pkg, bbs_index, bbs_update, bbs_store
//
//   channel   ports                                  dir  handshake
//   command   start, busy, item (item_t)             in   start & !busy
//   result    result_valid, result (result_t)        out  one-cycle strobe
//   config    cfg_we, cfg_index, cfg_data            in   cfg_we
//
// one word at a time: after accept a word passes the launch register and
// the seven-stage bin index pipeline; accumulate and read words then get
// a table read and the S_READ state, where accumulate words are written
// back, while dropped words and reads out of range go straight to idle
// after reset a clearing sweep zeroes all 175680 rows of the table; busy is
// high all that time, config writes are taken throughout
// results are strobed for one cycle and cannot be held off
`timescale 1ns / 1ps
`default_nettype none
module binned_backscatter_statistics import bbs_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire item_t                  item,
  output logic                        result_valid,
  output result_t                     result,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_CALC  = 2'd2;
  localparam logic [1:0] S_READ  = 2'd3;

  logic [1:0]  state;
  logic [1:0]  state_next;
  logic [7:0]  colocation_limit;
  logic [15:0] rain_limit;
  item_t       item_r;
  logic        launch;
  idx_t        idx;
  entry_t      rd_data;
  entry_t      new_row;
  logic        store_ready;
  logic        rd_en;
  logic        wr_en;
  logic        accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      colocation_limit <= COLOC_RESET;
      rain_limit       <= RAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLOC: colocation_limit <= cfg_data[7:0];
        CFG_RAIN:  rain_limit       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign rd_en  = (state == S_CALC) && idx.valid && idx.fetch;
  assign wr_en  = (state == S_READ) && !item_r.mode;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (store_ready) state_next = S_IDLE;
      S_IDLE:  if (start) state_next = S_CALC;
      S_CALC: begin
        if (idx.valid) begin
          state_next = idx.fetch ? S_READ : S_IDLE;
        end
      end
      S_READ:  state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      launch       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      launch       <= accept;
      result_valid <= ((state == S_CALC) && idx.valid && !idx.fetch)
                      || (state == S_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item;
    end
  end

  // result word: zeros for drops and reads out of range, table row for reads in range, new row otherwise
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      result.status         <= idx.status;
      result.bin_address    <= idx.bin_address;
      if (item_r.mode) begin
        result.bin_count      <= rd_data.count;
        result.bin_sum_sigma0 <= rd_data.sum_sigma0;
        result.bin_sum_square <= rd_data.sum_square;
        result.bin_sum_speed  <= rd_data.sum_speed;
        result.bin_sum_chi    <= rd_data.sum_chi;
        result.bin_sum_rain   <= rd_data.sum_rain;
      end else begin
        result.bin_count      <= new_row.count;
        result.bin_sum_sigma0 <= new_row.sum_sigma0;
        result.bin_sum_square <= new_row.sum_square;
        result.bin_sum_speed  <= new_row.sum_speed;
        result.bin_sum_chi    <= new_row.sum_chi;
        result.bin_sum_rain   <= new_row.sum_rain;
      end
    end else if ((state == S_CALC) && idx.valid) begin
      result.status         <= idx.status;
      result.bin_address    <= idx.bin_address;
      result.bin_count      <= '0;
      result.bin_sum_sigma0 <= '0;
      result.bin_sum_square <= '0;
      result.bin_sum_speed  <= '0;
      result.bin_sum_chi    <= '0;
      result.bin_sum_rain   <= '0;
    end
  end

  bbs_index u_index (
    .clk              (clk),
    .rst              (rst),
    .launch           (launch),
    .item             (item_r),
    .colocation_limit (colocation_limit),
    .rain_limit       (rain_limit),
    .idx              (idx)
  );

  bbs_update u_update (
    .old_row (rd_data),
    .sigma0  (item_r.sigma0),
    .square  (idx.square),
    .speed   (item_r.wind_speed),
    .chi     (idx.chi),
    .rain    (item_r.rain_raw),
    .new_row (new_row)
  );

  bbs_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (idx.addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (idx.addr),
    .wr_data (new_row),
    .ready   (store_ready)
  );

  // every launch is followed by a valid bin index, timed by IDX_LAT
  a_idx_latency: assert property (@(posedge clk) disable iff (rst)
    launch |-> ##IDX_LAT idx.valid)
    else $error("bin index late or missing");

  // index only completes while the sequencer waits for it
  a_idx_in_calc: assert property (@(posedge clk) disable iff (rst)
    idx.valid |-> (state == S_CALC))
    else $error("bin index outside calc state");

  // one result per word, never two in a row
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("back-to-back result words");

  // a result only follows work in progress
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without a word in flight");

endmodule
`default_nettype wire

[dv/bbs_bin_checker.sv]
// bbs_bin_checker: watches the command, result and config channels of the
// binned backscatter statistics block, keeps its own bin table and checks
// every result word; depends on bbs_pkg
`timescale 1ns / 1ps
module bbs_bin_checker import bbs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   busy,
  input  item_t                  item,
  input  logic                   result_valid,
  input  result_t                result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     pending,
  output int                     mismatches
);

  localparam longint SIGMA_HI = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SIGMA_LO = -SIGMA_HI - 1;

  entry_t     bin_table[int];
  result_t    due_results[$];
  logic [7:0]  coloc_lim;
  logic [15:0] rain_lim;
  result_t    want;

  function automatic logic [63:0] sat_add(logic [63:0] acc, logic [63:0] v,
                                          logic [63:0] ceiling);
    if (acc >= ceiling || v > ceiling - acc) return ceiling;
    return acc + v;
  endfunction

  function automatic result_t report(logic [1:0] st, logic [17:0] addr, entry_t e);
    result_t r;
    r.status         = st;
    r.bin_address    = addr;
    r.bin_count      = e.count;
    r.bin_sum_sigma0 = e.sum_sigma0;
    r.bin_sum_square = e.sum_square;
    r.bin_sum_speed  = e.sum_speed;
    r.bin_sum_chi    = e.sum_chi;
    r.bin_sum_rain   = e.sum_rain;
    return r;
  endfunction

  // expected result of one accepted word; accumulate words update the table
  function automatic result_t tally_word(item_t w);
    entry_t e;
    int     spd_bin, offset, rain_bin, chi, chi_bin, addr;
    longint s0, acc;
    e = '0;
    if (w.mode) begin
      if (w.read_bin < TOTAL_BINS && bin_table.exists(int'(w.read_bin)))
        e = bin_table[int'(w.read_bin)];
      return report(STAT_READ, w.read_bin, e);
    end
    spd_bin = int'(w.wind_speed) / 256;
    if (spd_bin >= SPEED_BINS) return report(STAT_SPEED, '0, e);
    offset = 2 * int'(w.time_offset) - COLOC_CENTER;
    if (offset < 0) offset = -offset;
    rain_bin = (w.rain_raw == 0) ? 0 : int'(w.rain_raw) / RAIN_STEP + 1;
    if (offset > int'(coloc_lim) || w.rain_raw > rain_lim || rain_bin >= RAIN_BINS)
      return report(STAT_RAIN, '0, e);
    chi     = (int'(w.wind_dir) + CHI_OFFSET - int'(w.meas_azimuth)) % CHI_FULL;
    chi_bin = chi * AZIMUTH_BINS / CHI_FULL;
    addr    = ((int'(w.beam) * SPEED_BINS + spd_bin) * AZIMUTH_BINS + chi_bin)
              * RAIN_BINS + rain_bin;
    if (bin_table.exists(addr)) e = bin_table[addr];
    s0 = longint'($signed(w.sigma0));
    if (e.count != COUNT_MAX) e.count = e.count + 1;
    acc = e.sum_sigma0;
    if (s0 > 0 && acc > SIGMA_HI - s0) acc = SIGMA_HI;
    else if (s0 < 0 && acc < SIGMA_LO - s0) acc = SIGMA_LO;
    else acc = acc + s0;
    e.sum_sigma0 = acc;
    e.sum_square = 63'(sat_add(64'(e.sum_square), 64'(s0 * s0), 64'(SQUARE_MAX)));
    e.sum_speed  = 48'(sat_add(64'(e.sum_speed), 64'(w.wind_speed), 64'(SUM48_MAX)));
    e.sum_chi    = 48'(sat_add(64'(e.sum_chi), 64'(chi), 64'(SUM48_MAX)));
    e.sum_rain   = 48'(sat_add(64'(e.sum_rain), 64'(w.rain_raw), 64'(SUM48_MAX)));
    bin_table[addr] = e;
    return report(STAT_ACC, 18'(addr), e);
  endfunction

  function automatic void note(string what, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s expected %h got %h", $time, what, exp_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      coloc_lim = COLOC_RESET;
      rain_lim  = RAIN_RESET;
      bin_table.delete();
      due_results.delete();
      mismatches <= 0;
    end else begin
      if (result_valid) begin
        if (due_results.size() == 0) begin
          $display("%0t: result word with none expected, got %h", $time, result);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          note("status", want.status, result.status);
          note("bin_address", want.bin_address, result.bin_address);
          note("bin_count", want.bin_count, result.bin_count);
          note("bin_sum_sigma0", want.bin_sum_sigma0, result.bin_sum_sigma0);
          note("bin_sum_square", want.bin_sum_square, result.bin_sum_square);
          note("bin_sum_speed", want.bin_sum_speed, result.bin_sum_speed);
          note("bin_sum_chi", want.bin_sum_chi, result.bin_sum_chi);
          note("bin_sum_rain", want.bin_sum_rain, result.bin_sum_rain);
        end
      end
      if (start && !busy) due_results.push_back(tally_word(item));
      if (cfg_we) begin
        if (cfg_index == CFG_COLOC) coloc_lim = cfg_data[7:0];
        else if (cfg_index == CFG_RAIN) rain_lim = cfg_data;
      end
    end
    pending <= due_results.size();
  end

endmodule

[dv/binned_backscatter_statistics_test.sv]
// binned_backscatter_statistics_test: clock, reset, directed and random
// command words and config phases; depends on bbs_pkg and bbs_bin_checker
`timescale 1ns / 1ps
module binned_backscatter_statistics_test;
  import bbs_pkg::*;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  item_t                  item;
  logic                   result_valid;
  result_t                result;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     pending;
  int                     mismatches;

  int          coloc_now = COLOC_RESET;
  int          rain_now  = RAIN_RESET;
  logic [15:0] hot_speed[6], hot_dir[6], hot_az[6], hot_rain[6];
  logic [17:0] seen_bins[32];
  int          seen_next = 0;
  int          seen_fill = 0;

  binned_backscatter_statistics dut (
    .clk, .rst, .start, .busy, .item, .result_valid, .result,
    .cfg_we, .cfg_index, .cfg_data
  );

  bbs_bin_checker bin_check (
    .clk, .rst, .start, .busy, .item, .result_valid, .result,
    .cfg_we, .cfg_index, .cfg_data, .pending, .mismatches
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // bins that really got written, so reads mostly hit live data
  always @(posedge clk) begin
    if (result_valid && result.status == STAT_ACC) begin
      seen_bins[seen_next] <= result.bin_address;
      seen_next <= (seen_next + 1) % 32;
      if (seen_fill < 32) seen_fill <= seen_fill + 1;
    end
  end

  task automatic put_word(input item_t w);
    start <= 1'b1;
    item  <= w;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_limits(input int coloc, input int rain);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COLOC;
    cfg_data  <= CFG_DATA_W'(coloc);
    @(posedge clk);
    cfg_index <= CFG_RAIN;
    cfg_data  <= CFG_DATA_W'(rain);
    @(posedge clk);
    cfg_we    <= 1'b0;
    coloc_now = coloc;
    rain_now  = rain;
  endtask

  task automatic seed_hot_bins();
    for (int k = 0; k < 6; k++) begin
      hot_speed[k] = $urandom_range(0, SPEED_BINS * 256 - 1);
      hot_dir[k]   = $urandom_range(0, CHI_FULL - 1);
      hot_az[k]    = $urandom_range(0, CHI_FULL - 1);
      hot_rain[k]  = $urandom_range(0, (rain_now < 299) ? rain_now : 299);
    end
  endtask

  function automatic item_t noise_word();
    item_t w;
    w.mode         = $urandom;
    w.beam         = $urandom;
    w.wind_speed   = $urandom;
    w.wind_dir     = $urandom;
    w.meas_azimuth = $urandom;
    w.sigma0       = $urandom;
    w.time_offset  = $urandom;
    w.rain_raw     = $urandom;
    w.read_bin     = $urandom;
    return w;
  endfunction

  function automatic item_t meas(input logic b, input int spd, input int dir,
                                 input int az, input logic [31:0] sig,
                                 input int toff, input int rain);
    item_t w;
    w = noise_word();
    w.mode         = 1'b0;
    w.beam         = b;
    w.wind_speed   = 16'(spd);
    w.wind_dir     = 16'(dir);
    w.meas_azimuth = 16'(az);
    w.sigma0       = sig;
    w.time_offset  = 8'(toff);
    w.rain_raw     = 16'(rain);
    return w;
  endfunction

  function automatic item_t readout(input int addr);
    item_t w;
    w = noise_word();
    w.mode     = 1'b1;
    w.read_bin = 18'(addr);
    return w;
  endfunction

  function automatic logic [31:0] pick_sigma();
    case ($urandom_range(0, 4))
      0:       return $urandom;
      1:       return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      default: return $urandom_range(0, 1 << 24);
    endcase
  endfunction

  // mostly measurements that get past every drop check, some reads, some noise
  function automatic item_t pick_word();
    item_t w;
    int    r, k, half;
    w = noise_word();
    r = $urandom_range(0, 99);
    if (r >= 80) return w;
    if (r >= 62) begin
      w.mode = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 70 && seen_fill > 0) w.read_bin = seen_bins[$urandom_range(0, seen_fill - 1)];
      else if (r < 85) w.read_bin = $urandom_range(0, TOTAL_BINS - 1);
      return w;
    end
    w.mode = 1'b0;
    if ($urandom_range(0, 1)) begin
      k = $urandom_range(0, 5);
      w.wind_speed   = hot_speed[k];
      w.wind_dir     = hot_dir[k];
      w.meas_azimuth = hot_az[k];
      w.rain_raw     = hot_rain[k];
    end else begin
      w.wind_speed = $urandom_range(0, SPEED_BINS * 256 - 1);
      if ($urandom_range(0, 9) != 0) begin
        w.wind_dir     = $urandom_range(0, CHI_FULL - 1);
        w.meas_azimuth = $urandom_range(0, CHI_FULL - 1);
      end
      w.rain_raw = ($urandom_range(0, 4) == 0) ? 16'd0 :
                   16'($urandom_range(0, (rain_now < 299) ? rain_now : 299));
    end
    half = (coloc_now / 2 < 90) ? coloc_now / 2 : 90;
    k = $urandom_range(0, half);
    w.time_offset = $urandom_range(0, 1) ? 8'(90 + k) : 8'(90 - k);
    w.sigma0 = pick_sigma();
    return w;
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 12);
    return $urandom_range(13, 40);
  endfunction

  task automatic run_phase(input int n);
    int gap;
    for (int i = 0; i < n; i++) begin
      put_word(pick_word());
      if ($urandom_range(0, 199) == 0) begin
        settle();
      end else if ((i / 40) % 3 != 2) begin
        gap = idle_gap();
        if (gap > 0) hold_off(gap);
      end
    end
    settle();
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    item      = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset limits: colocation 30, rain 1000
    put_word(readout(0));
    put_word(readout(TOTAL_BINS - 1));
    put_word(readout(TOTAL_BINS));
    put_word(readout(18'h3FFFF));
    put_word(meas(0, 0, 0, 0, 32'h7FFF_FFFF, 90, 0));
    put_word(meas(0, 0, 0, 0, 32'h8000_0000, 90, 0));
    put_word(meas(0, 0, 0, 0, 32'h0, 90, 0));
    put_word(readout((AZIMUTH_BINS / 2) * RAIN_BINS));
    put_word(meas(0, SPEED_BINS * 256, 100, 200, 32'h100, 90, 5));
    // speed check wins over bad colocation and bad rain
    put_word(meas(1, 16'hFFFF, 100, 200, 32'h100, 0, 16'hFFFF));
    // lands in the very last bin
    put_word(meas(1, SPEED_BINS * 256 - 1, CHI_FULL / 2 - 1, 0, 32'hFFFF_FFFF, 90, 299));
    put_word(readout(TOTAL_BINS - 1));
    put_word(meas(0, 1000, 5000, 3000, 32'h10000, 105, 7));
    put_word(meas(0, 1000, 5000, 3000, 32'h10000, 106, 7));
    put_word(meas(1, 1000, 5000, 3000, 32'h10000, 75, 7));
    put_word(meas(1, 1000, 5000, 3000, 32'h10000, 74, 7));
    put_word(meas(0, 1000, 5000, 3000, 32'h10000, 0, 7));
    put_word(meas(0, 1000, 5000, 3000, 32'h10000, 255, 7));
    put_word(meas(0, 2000, 5000, 3000, 32'h10000, 90, 300));
    put_word(meas(0, 2000, 5000, 3000, 32'h10000, 90, 1000));
    put_word(meas(0, 2000, 5000, 3000, 32'h10000, 90, 1001));
    put_word(meas(1, 3000, 16'hFFFF, 0, 32'h2000, 90, 1));
    put_word(meas(1, 3000, 0, 16'hFFFF, 32'h2000, 90, 1));
    put_word(meas(0, 3000, 0, CHI_FULL / 2, 32'h2000, 90, 1));
    settle();

    seed_hot_bins();
    run_phase(300);
    set_limits(255, 65535);
    seed_hot_bins();
    run_phase(300);
    set_limits(0, 0);
    seed_hot_bins();
    run_phase(250);
    set_limits($urandom_range(1, 254), $urandom_range(1, 65534));
    seed_hot_bins();
    run_phase(300);
    set_limits(30, 1000);
    seed_hot_bins();
    run_phase(300);

    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
